/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/sfs_pkg.sv */
// ---------------------------------------------------------------------------
// Sample frame serializer package
// Widths, codes, packet type and CRC/hex helpers shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

   localparam int COUNT_W  = 20;
   localparam int SAMPLE_W = 16;
   localparam int BYTE_W   = 8;

   // Largest number of bytes one transaction can produce
   localparam int PKT_DEPTH = 10;
   localparam int PKT_IDX_W = $clog2(PKT_DEPTH);

   localparam int MAX_SAMPLES_DEFAULT = 50000;

   // Action codes
   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Output mode codes
   localparam logic MODE_BINARY = 1'b0;
   localparam logic MODE_HEX    = 1'b1;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [BYTE_W-1:0] HEADER_TOP = 8'hF0;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_ALPHA = 8'h37;

   // Bytes of one transaction, byte 0 goes out first
   typedef struct packed {
      logic [PKT_DEPTH-1:0][BYTE_W-1:0] data;
      logic [PKT_DEPTH-1:0]             last;
      logic [PKT_DEPTH-1:0]             done;
      logic                             status;
      logic [PKT_IDX_W-1:0]             count;
   } pkt_type;

   // One byte of CRC-16/CCITT-FALSE, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [BYTE_W-1:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Uppercase hex character of one nibble
   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (CHAR_ZERO + {4'h0, nib}) : (CHAR_ALPHA + {4'h0, nib});
   endfunction

   // Four hex characters and a space, element 0 first on the link
   function automatic logic [4:0][BYTE_W-1:0] hex_word(input logic [SAMPLE_W-1:0] w);
      logic [4:0][BYTE_W-1:0] b;
      b[0] = hex_char(w[15:12]);
      b[1] = hex_char(w[11:8]);
      b[2] = hex_char(w[7:4]);
      b[3] = hex_char(w[3:0]);
      b[4] = CHAR_SPACE;
      return b;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfs_framer.sv */
// ---------------------------------------------------------------------------
// Frame builder
// Holds the frame state and turns one registered item into a byte packet.
// ---------------------------------------------------------------------------
`default_nettype none

module sfs_framer
   import sfs_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic                output_mode,
   input  wire logic                action,
   input  wire logic [COUNT_W-1:0]  sample_count,
   input  wire logic [SAMPLE_W-1:0] sample_value,
   output      pkt_type             pkt,
   output      logic                pkt_valid
);

   logic [15:0]        crc_ff, crc_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               open_ff, open_in;

   logic [15:0]        crc_next;
   logic [COUNT_W-1:0] left_dec;
   logic               bad_count;

   assign crc_next  = crc_byte(crc_byte(crc_ff, sample_value[15:8]), sample_value[7:0]);
   assign left_dec  = left_ff - COUNT_W'(1);
   assign bad_count = (sample_count == '0) || (sample_count > COUNT_W'(MAX_SAMPLES));

   // Build the packet and the next frame state
   always_comb begin
      pkt     = '0;
      crc_in  = crc_ff;
      left_in = left_ff;
      open_in = open_ff;
      if (action == ACT_START) begin
         crc_in = CRC_INIT;
         if (bad_count) begin
            open_in       = 1'b0;
            left_in       = '0;
            pkt.status    = 1'b1;
            pkt.last[0]   = 1'b1;
            pkt.count     = PKT_IDX_W'(1);
         end else begin
            open_in = 1'b1;
            left_in = sample_count;
            if (output_mode == MODE_HEX) begin
               pkt.data[0] = CHAR_CR;
               pkt.data[1] = CHAR_LF;
               pkt.last[1] = 1'b1;
               pkt.count   = PKT_IDX_W'(2);
            end else begin
               pkt.data[0] = HEADER_TOP | {4'h0, sample_count[19:16]};
               pkt.data[1] = sample_count[15:8];
               pkt.data[2] = sample_count[7:0];
               pkt.last[2] = 1'b1;
               pkt.count   = PKT_IDX_W'(3);
            end
         end
      end else if (open_ff) begin
         if (left_dec != '0) begin
            // Middle of frame: the sample alone
            crc_in  = crc_next;
            left_in = left_dec;
            if (output_mode == MODE_HEX) begin
               pkt.data[4:0] = hex_word(sample_value);
               pkt.last[4]   = 1'b1;
               pkt.count     = PKT_IDX_W'(5);
            end else begin
               pkt.data[1:0] = {sample_value[7:0], sample_value[15:8]};
               pkt.last[1]   = 1'b1;
               pkt.count     = PKT_IDX_W'(2);
            end
         end else begin
            // Last sample: the sample, then the CRC, then close the frame
            crc_in  = CRC_INIT;
            left_in = '0;
            open_in = 1'b0;
            if (output_mode == MODE_HEX) begin
               pkt.data[4:0] = hex_word(sample_value);
               pkt.data[9:5] = hex_word(crc_next);
               pkt.last[9]   = 1'b1;
               pkt.done[9]   = 1'b1;
               pkt.count     = PKT_IDX_W'(10);
            end else begin
               pkt.data[1:0] = {sample_value[7:0], sample_value[15:8]};
               pkt.data[3:2] = {crc_next[7:0], crc_next[15:8]};
               pkt.last[3]   = 1'b1;
               pkt.done[3]   = 1'b1;
               pkt.count     = PKT_IDX_W'(4);
            end
         end
      end
   end

   assign pkt_valid = fire && (pkt.count != '0);

   // Advance frame state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else if (fire) begin
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sfs_serializer.sv */
// ---------------------------------------------------------------------------
// Byte serializer
// Holds one packet and sends its bytes one per transaction on the result side.
// ---------------------------------------------------------------------------
`default_nettype none

module sfs_serializer
   import sfs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pkt_type           pkt,
   input  wire logic              pkt_valid,
   output      logic              pkt_free,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [BYTE_W-1:0] rsp_out_byte,
   output      logic              rsp_status,
   output      logic              rsp_last,
   output      logic              rsp_frame_done
);

   pkt_type              pkt_ff;
   logic                 valid_ff, valid_in;
   logic [PKT_IDX_W-1:0] idx_ff, idx_in;
   logic                 take, fin;

   assign take     = valid_ff && !rsp_stall;
   assign fin      = take && (idx_ff == pkt_ff.count - PKT_IDX_W'(1));
   assign pkt_free = !valid_ff || fin;

   // Load a new packet when the held one is gone, else step through it
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pkt_free) begin
         valid_in = pkt_valid;
         idx_in   = '0;
      end else if (take) begin
         idx_in = idx_ff + PKT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Packet payload, no reset needed
   always_ff @(posedge clock) begin
      if (pkt_free && pkt_valid) begin
         pkt_ff <= pkt;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = pkt_ff.data[idx_ff];
   assign rsp_status     = pkt_ff.status;
   assign rsp_last       = pkt_ff.last[idx_ff];
   assign rsp_frame_done = pkt_ff.done[idx_ff];

endmodule

`default_nettype wire

/* hw/rtl/sample_frame_serializer_crc16.sv */
// ---------------------------------------------------------------------------
// Sample frame serializer with CRC-16
// Frames a dump of 16-bit samples into binary or hex bytes with a CRC trailer.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a start (req_action = 0, req_sample_count) or a
//   sample (req_action = 1, req_sample_value). rsp_* carries one frame byte
//   per transaction with status, last and frame_done flags. csr_* writes the
//   output mode (0 binary, 1 hex); csr_ready is always high, write it only
//   while the block is idle.
//   An item passes through the input register and then the packet register
//   before its first byte is valid on rsp_*. While rsp_stall is low the
//   serializer sends one byte per cycle. An item has 2 (binary) or 5 (hex)
//   bytes for a sample, 4 or 10 for the last sample with its CRC, 3 or 2 for
//   a header and 1 for a rejected start; an ignored sample yields no bytes
//   and only passes through the input register. One further item is taken
//   into the input register while earlier bytes drain.
//   Reset clears the mode to binary and closes any open frame.
//   A stall on rsp_* holds the current byte; the packet register then fills
//   and req_stall rises once the input register is also occupied.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sample_frame_serializer_crc16
   import sfs_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_action,
   input  wire logic [COUNT_W-1:0]  req_sample_count,
   input  wire logic [SAMPLE_W-1:0] req_sample_value,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [BYTE_W-1:0]   rsp_out_byte,
   output      logic                rsp_status,
   output      logic                rsp_last,
   output      logic                rsp_frame_done,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic                csr_output_mode
);

   logic                in_valid_ff, in_valid_in;
   logic                in_action_ff;
   logic [COUNT_W-1:0]  in_count_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                mode_ff;

   logic                req_accept, fire, pkt_free, pkt_valid;
   pkt_type             pkt;

   // Mode register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BINARY;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_output_mode;
      end
   end

   // Input register: hold while the packet register is busy
   assign fire       = in_valid_ff && pkt_free;
   assign req_stall  = in_valid_ff && !pkt_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= req_action;
         in_count_ff  <= req_sample_count;
         in_sample_ff <= req_sample_value;
      end
   end

   sfs_framer #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .output_mode  (mode_ff),
      .action       (in_action_ff),
      .sample_count (in_count_ff),
      .sample_value (in_sample_ff),
      .pkt          (pkt),
      .pkt_valid    (pkt_valid)
   );

   sfs_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .pkt            (pkt),
      .pkt_valid      (pkt_valid),
      .pkt_free       (pkt_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .rsp_frame_done (rsp_frame_done)
   );

   // A rejected start is a single byte that closes nothing
   `ASSERT_IMPL(a_status_alone, clock, reset, rsp_valid && rsp_status, rsp_last && !rsp_frame_done)
   // The frame's final byte also ends its item
   `ASSERT_IMPL(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done, rsp_last)
   // A held item stays in the input register
   `ASSERT_NEXT(a_input_held, clock, reset, req_stall, in_valid_ff)
   // The input register only empties into a free packet register
   `ASSERT_NEXT(a_no_drop, clock, reset, in_valid_ff && !pkt_free, in_valid_ff)

endmodule

`default_nettype wire

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// Sample frame serializer testbench
// Drives start and sample transactions in binary and hex mode, predicts every
// frame byte with its status, last and frame_done flags, and compares each
// accepted byte in order. A directed table comes first, then random frames.
// ---------------------------------------------------------------------------
module tb;
   import sfs_pkg::*;

   localparam int RAND_ITEMS    = 100;
   localparam int QUIET_ITEMS   = 25;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_SETTLE  = 20;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 40;

   // One byte on the link with its flags
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              status;
      logic              last;
      logic              done;
   } frame_byte_type;

   typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_type;

   // One row of the directed table
   typedef struct packed {
      row_kind_type                kind;
      logic                        mode;
      logic                        action;
      logic [COUNT_W-1:0]          count;
      logic [SAMPLE_W-1:0]         value;
      logic [1:0]                  n_typed;
      frame_byte_type [0:2]        typed;
   } stim_row_type;

   localparam frame_byte_type REJECT_BYTE = '{8'h00, 1'b1, 1'b1, 1'b0};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [COUNT_W-1:0]  req_sample_count;
   logic [SAMPLE_W-1:0] req_sample_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_status;
   logic                rsp_last;
   logic                rsp_frame_done;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_output_mode;

   // Predictor state
   logic                mode_q;
   logic [15:0]         crc_q;
   logic [COUNT_W-1:0]  left_q;
   logic                open_q;

   frame_byte_type      step_bytes[$];
   frame_byte_type      pending_bytes[$];
   stim_row_type        dir_table[$];
   int                  mismatches;
   int                  items_done;
   bit                  quiet;

   sample_frame_serializer_crc16 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_sample_count (req_sample_count),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .rsp_frame_done   (rsp_frame_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_output_mode  (csr_output_mode)
   );

   // Generate clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End a hung run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic log_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // CRC-16/CCITT-FALSE over one word, bit by bit from the MSB
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [15:0] w);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 15; i >= 0; i--) begin
         fb = c[15] ^ w[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
      if (nib < 4'd10)
         return 8'h30 + {4'h0, nib};
      return 8'h41 + {4'h0, nib} - 8'd10;
   endfunction

   function automatic frame_byte_type link_byte(input logic [7:0] data, input logic last);
      return '{data, 1'b0, last, 1'b0};
   endfunction

   // Emit one word in the current format
   task automatic put_word(input logic [15:0] w, input logic end_item, input logic end_frame);
      if (mode_q == MODE_HEX) begin
         for (int i = 0; i < 4; i++)
            step_bytes.push_back(link_byte(ascii_nibble(4'(w >> (12 - 4 * i))), 1'b0));
         step_bytes.push_back('{CHAR_SPACE, 1'b0, end_item, end_frame});
      end else begin
         step_bytes.push_back(link_byte(w[15:8], 1'b0));
         step_bytes.push_back('{w[7:0], 1'b0, end_item, end_frame});
      end
   endtask

   // Predict the bytes that one accepted transaction produces
   task automatic frame_model(input logic action, input logic [COUNT_W-1:0] count,
                              input logic [SAMPLE_W-1:0] value);
      step_bytes.delete();
      if (action == ACT_START) begin
         open_q = 1'b0;
         left_q = '0;
         crc_q  = CRC_INIT;
         if (count == 0 || count > MAX_SAMPLES_DEFAULT) begin
            step_bytes.push_back(REJECT_BYTE);
            return;
         end
         if (mode_q == MODE_HEX) begin
            step_bytes.push_back(link_byte(CHAR_CR, 1'b0));
            step_bytes.push_back(link_byte(CHAR_LF, 1'b1));
         end else begin
            step_bytes.push_back(link_byte(HEADER_TOP | {4'h0, count[19:16]}, 1'b0));
            step_bytes.push_back(link_byte(count[15:8], 1'b0));
            step_bytes.push_back(link_byte(count[7:0], 1'b1));
         end
         left_q = count;
         open_q = 1'b1;
      end else if (open_q) begin
         crc_q  = crc_next(crc_q, value);
         left_q = left_q - 1'b1;
         if (left_q != 0) begin
            put_word(value, 1'b1, 1'b0);
         end else begin
            put_word(value, 1'b0, 1'b0);
            put_word(crc_q, 1'b1, 1'b1);
            open_q = 1'b0;
            crc_q  = CRC_INIT;
         end
      end
   endtask

   // Drive one transaction, starting and ending at a falling edge
   task automatic send_item(input logic action, input logic [COUNT_W-1:0] count,
                            input logic [SAMPLE_W-1:0] value, input int n_typed,
                            input frame_byte_type [0:2] typed);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_sample_count <= count;
      req_sample_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_model(action, count, value);
      if (n_typed > 0) begin
         for (int i = 0; i < n_typed; i++) pending_bytes.push_back(typed[i]);
      end else begin
         foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      end
      if (step_bytes.size() != 0) items_done++;
      @(negedge clock);
   endtask

   // Hold the input idle until every expected byte is out, then settle
   task automatic drain(input int settle);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_bytes.size() != 0) begin
         log_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
         pending_bytes.delete();
      end
      repeat (settle) @(negedge clock);
   endtask

   // Write the output mode while the block is idle
   task automatic write_mode(input logic mode);
      drain(SETTLE_CYCLES);
      csr_valid       <= 1'b1;
      csr_output_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_q = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic stim_row_type item_row(input logic action,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [SAMPLE_W-1:0] value,
                                             input int n_typed = 0,
                                             input frame_byte_type t0 = '0,
                                             input frame_byte_type t1 = '0,
                                             input frame_byte_type t2 = '0);
      stim_row_type r;
      r = '0;
      r.kind     = ROW_ITEM;
      r.action   = action;
      r.count    = count;
      r.value    = value;
      r.n_typed  = 2'(n_typed);
      r.typed[0] = t0;
      r.typed[1] = t1;
      r.typed[2] = t2;
      return r;
   endfunction

   function automatic stim_row_type mode_row(input logic mode);
      stim_row_type r;
      r = '0;
      r.kind = ROW_MODE;
      r.mode = mode;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One start with its samples; may stop early or change mode midway
   task automatic random_frame();
      logic [COUNT_W-1:0] cnt;
      int                 stop;
      int                 flip_at;
      int                 r;
      r = $urandom_range(0, 19);
      if (r < 14)
         cnt = COUNT_W'($urandom_range(1, 4));
      else if (r < 19)
         cnt = COUNT_W'($urandom_range(5, 12));
      else
         cnt = COUNT_W'(MAX_SAMPLES_DEFAULT);
      if (cnt == MAX_SAMPLES_DEFAULT)
         stop = $urandom_range(1, 3);
      else if ($urandom_range(0, 6) == 0)
         stop = $urandom_range(0, cnt - 1);
      else
         stop = cnt;
      flip_at = (stop > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, stop - 1) : -1;
      send_item(ACT_START, cnt, 16'($urandom), 0, '0);
      for (int i = 0; i < stop; i++) begin
         if (i == flip_at) write_mode(~mode_q);
         send_item(ACT_SAMPLE, COUNT_W'($urandom), rand_sample(), 0, '0);
      end
   endtask

   // Stall the result side in random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   // Compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_bytes.size() == 0) begin
            log_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               log_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, want.data));
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status %0b, want %0b", rsp_status, want.status));
            if (rsp_last !== want.last)
               log_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                      rsp_last, want.last, want.data));
            if (rsp_frame_done !== want.done)
               log_mismatch($sformatf("frame_done %0b, want %0b on byte %02h",
                                      rsp_frame_done, want.done, want.data));
         end
      end
   end

   // Main sequence
   initial begin
      int pick;
      logic [COUNT_W-1:0] bad;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_START;
      req_sample_count = '0;
      req_sample_value = '0;
      csr_valid        = 1'b0;
      csr_output_mode  = MODE_BINARY;
      mode_q           = MODE_BINARY;
      crc_q            = CRC_INIT;
      left_q           = '0;
      open_q           = 1'b0;
      mismatches       = 0;
      items_done       = 0;
      quiet            = 1'b0;

      dir_table = '{
         // rejected counts: zero, one above the limit, all ones
         item_row(ACT_START, 20'd0, 16'h0000, 1, REJECT_BYTE),
         item_row(ACT_START, 20'd50001, 16'hFFFF, 1, REJECT_BYTE),
         item_row(ACT_START, 20'hFFFFF, 16'h0000, 1, REJECT_BYTE),
         // sample with no open frame
         item_row(ACT_SAMPLE, 20'hFFFFF, 16'hFFFF),
         item_row(ACT_START, 20'd1, 16'h0000, 3, link_byte(8'hF0, 1'b0),
                  link_byte(8'h00, 1'b0), link_byte(8'h01, 1'b1)),
         item_row(ACT_SAMPLE, 20'd0, 16'h0000),
         item_row(ACT_START, 20'd50000, 16'h0000, 3, link_byte(8'hF0, 1'b0),
                  link_byte(8'hC3, 1'b0), link_byte(8'h50, 1'b1)),
         item_row(ACT_SAMPLE, 20'd0, 16'hFFFF),
         item_row(ACT_SAMPLE, 20'd0, 16'h8001),
         // start while a frame is open
         item_row(ACT_START, 20'd2, 16'h0000, 3, link_byte(8'hF0, 1'b0),
                  link_byte(8'h00, 1'b0), link_byte(8'h02, 1'b1)),
         item_row(ACT_SAMPLE, 20'd0, 16'h1234),
         // mode change inside a frame, hex last sample with its CRC
         mode_row(MODE_HEX),
         item_row(ACT_SAMPLE, 20'd0, 16'hABCD),
         item_row(ACT_SAMPLE, 20'd0, 16'h0F0F),
         item_row(ACT_START, 20'd0, 16'h0000, 1, REJECT_BYTE),
         item_row(ACT_START, 20'd3, 16'h0000, 2, link_byte(CHAR_CR, 1'b0),
                  link_byte(CHAR_LF, 1'b1)),
         item_row(ACT_SAMPLE, 20'd0, 16'h0000),
         mode_row(MODE_BINARY),
         item_row(ACT_SAMPLE, 20'd0, 16'hFFFF),
         mode_row(MODE_HEX),
         item_row(ACT_SAMPLE, 20'd0, 16'h5A5A),
         item_row(ACT_START, 20'd1, 16'h0000, 2, link_byte(CHAR_CR, 1'b0),
                  link_byte(CHAR_LF, 1'b1)),
         item_row(ACT_SAMPLE, 20'd0, 16'h9C6E),
         mode_row(MODE_BINARY),
         item_row(ACT_START, 20'd50001, 16'h0000, 1, REJECT_BYTE)
      };

      // Hold reset, then release it at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_MODE)
            write_mode(dir_table[i].mode);
         else
            send_item(dir_table[i].action, dir_table[i].count, dir_table[i].value,
                      dir_table[i].n_typed, dir_table[i].typed);
      end

      // Random frames mixed with rejected starts, stray samples and mode writes
      items_done = 0;
      while (items_done < RAND_ITEMS) begin
         quiet = (items_done >= RAND_ITEMS - QUIET_ITEMS);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            write_mode(1'($urandom_range(0, 1)));
         end else if (pick < 16) begin
            case ($urandom_range(0, 3))
               0: bad = '0;
               1: bad = 20'hFFFFF;
               2: bad = COUNT_W'(MAX_SAMPLES_DEFAULT + 1);
               default: bad = COUNT_W'($urandom_range(MAX_SAMPLES_DEFAULT + 1, 20'hFFFFF));
            endcase
            send_item(ACT_START, bad, 16'($urandom), 0, '0);
         end else if (pick < 22) begin
            send_item(ACT_SAMPLE, COUNT_W'($urandom), rand_sample(), 0, '0);
         end else begin
            random_frame();
         end
      end

      quiet = 1'b1;
      drain(FINAL_SETTLE);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
